// ===== rtl/segment_rect_intersect_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the segment/rectangle intersection unit
// Both macros sample on the rising edge of clock and are disabled by reset.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_RECT_INTERSECT_UNIT_ASSERT_SVH
`define SEGMENT_RECT_INTERSECT_UNIT_ASSERT_SVH

// Same-cycle implication
`define SRI_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sri: property violated");

// Implication checked a fixed number of cycles later
`define SRI_ASSERT_DLY(lbl, ante, dly, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##(dly) (cons)) \
      else $error("sri: delayed property violated");

`endif

// ===== rtl/sri_pkg.sv =====
// ----------------------------------------------------------------------------
// sri_pkg
// Shared edge indexes, mask type and pipeline latency of the intersection unit.
// ----------------------------------------------------------------------------
package sri_pkg;

   // Rectangle edges, in mask bit order
   localparam int NUM_EDGES   = 4;
   localparam int EDGE_TOP    = 0;
   localparam int EDGE_RIGHT  = 1;
   localparam int EDGE_BOTTOM = 2;
   localparam int EDGE_LEFT   = 3;

   // Clock edges from item acceptance to the edge that takes the result
   localparam int PIPE_LATENCY = 4;

   typedef logic [NUM_EDGES-1:0] edge_mask_type;

endpackage

// ===== rtl/segment_rect_intersect_unit.sv =====
// ----------------------------------------------------------------------------
// segment_rect_intersect_unit
// Tests one line segment against each edge of an axis-aligned rectangle.
// ----------------------------------------------------------------------------
// Usage:
//   An item (segment ends and rectangle corner, signed fixed point; size
//   unsigned) is accepted at a rising edge with start high and busy low. busy
//   is high only while reset is asserted, so one item can enter every cycle.
//   Each result (hit flag and per-edge mask: top, right, bottom, left) shows
//   on the rsp_ ports for exactly one cycle with rsp_valid high, and is taken
//   at the edge that ends that cycle; the receiver cannot stall.
// Pipeline and throughput:
//   An item passes four register stages (differences, products, numerator
//   subtract, range compares) before its result shows on the rsp_ ports.
//   Throughput is one item per cycle; results leave in acceptance order.
// Reset:
//   Synchronous, active high; clears all stage valid bits, so items in
//   flight are dropped and no result appears until new items enter.
// Parallel or collinear edges and zero-length segments count as misses.
// ----------------------------------------------------------------------------
module segment_rect_intersect_unit #(
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_BITS-1:0]  req_seg_x0,
   input  logic signed [COORD_BITS-1:0]  req_seg_y0,
   input  logic signed [COORD_BITS-1:0]  req_seg_x1,
   input  logic signed [COORD_BITS-1:0]  req_seg_y1,
   input  logic signed [COORD_BITS-1:0]  req_box_left,
   input  logic signed [COORD_BITS-1:0]  req_box_top,
   input  logic        [COORD_BITS-2:0]  req_box_width,
   input  logic        [COORD_BITS-2:0]  req_box_height,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output sri_pkg::edge_mask_type        rsp_edge_mask
);
   import sri_pkg::*;

   // Widths: segment delta, corner offset, edge length, compare word
   localparam int BW = COORD_BITS + 1;
   localparam int CW = COORD_BITS + 2;
   localparam int FW = COORD_BITS;
   localparam int DW = BW + FW;
   localparam int TW = CW + FW;
   localparam int UW = CW + BW;
   localparam int PW = 2 * COORD_BITS + 4;

   // num/den within [0,1] for a nonzero den, both ends inclusive
   function automatic logic in_unit(input logic signed [PW-1:0] num,
                                    input logic signed [PW-1:0] den);
      logic [PW:0] d_m_n;
      logic [PW:0] n_m_d;
      logic        num_neg;
      logic        num_zero;
      d_m_n    = {den[PW-1], den} - {num[PW-1], num};
      n_m_d    = {num[PW-1], num} - {den[PW-1], den};
      num_neg  = num[PW-1];
      num_zero = (num == '0);
      if (!den[PW-1]) begin
         in_unit = !num_neg && !d_m_n[PW];
      end else begin
         in_unit = (num_neg || num_zero) && !n_m_d[PW];
      end
   endfunction

   // Accept whenever out of reset
   assign busy = reset;

   logic accept;
   assign accept = start && !busy;

   // ---------------------------------------------------------------- stage 1
   logic signed [BW-1:0] bx_in, by_in, rx, bot, lxe, tye;
   logic signed [BW-1:0] ex [NUM_EDGES];
   logic signed [BW-1:0] ey [NUM_EDGES];
   logic signed [CW-1:0] cx_in [NUM_EDGES];
   logic signed [CW-1:0] cy_in [NUM_EDGES];
   logic signed [FW-1:0] f_in  [NUM_EDGES];
   logic signed [BW-1:0] a_in  [NUM_EDGES];
   logic signed [CW-1:0] n_in  [NUM_EDGES];

   logic                 s1_valid_ff;
   logic signed [BW-1:0] s1_bx_ff, s1_by_ff;
   logic signed [BW-1:0] s1_a_ff  [NUM_EDGES];
   logic signed [FW-1:0] s1_f_ff  [NUM_EDGES];
   logic signed [CW-1:0] s1_n_ff  [NUM_EDGES];
   logic signed [CW-1:0] s1_cx_ff [NUM_EDGES];
   logic signed [CW-1:0] s1_cy_ff [NUM_EDGES];

   // Form segment delta, corners, corner offsets and signed edge lengths
   always_comb begin
      bx_in = {req_seg_x1[COORD_BITS-1], req_seg_x1} - {req_seg_x0[COORD_BITS-1], req_seg_x0};
      by_in = {req_seg_y1[COORD_BITS-1], req_seg_y1} - {req_seg_y0[COORD_BITS-1], req_seg_y0};
      lxe   = {req_box_left[COORD_BITS-1], req_box_left};
      tye   = {req_box_top[COORD_BITS-1], req_box_top};
      rx    = lxe + {2'b00, req_box_width};
      bot   = tye + {2'b00, req_box_height};

      ex[EDGE_TOP]    = lxe;  ey[EDGE_TOP]    = tye;
      ex[EDGE_RIGHT]  = rx;   ey[EDGE_RIGHT]  = tye;
      ex[EDGE_BOTTOM] = rx;   ey[EDGE_BOTTOM] = bot;
      ex[EDGE_LEFT]   = lxe;  ey[EDGE_LEFT]   = bot;

      // Horizontal edges use -dx against by/cy, vertical ones dy against bx/cx
      f_in[EDGE_TOP]    = FW'(0) - {1'b0, req_box_width};
      f_in[EDGE_RIGHT]  = {1'b0, req_box_height};
      f_in[EDGE_BOTTOM] = {1'b0, req_box_width};
      f_in[EDGE_LEFT]   = FW'(0) - {1'b0, req_box_height};

      for (int k = 0; k < NUM_EDGES; k++) begin
         cx_in[k] = {ex[k][BW-1], ex[k]} - {{2{req_seg_x0[COORD_BITS-1]}}, req_seg_x0};
         cy_in[k] = {ey[k][BW-1], ey[k]} - {{2{req_seg_y0[COORD_BITS-1]}}, req_seg_y0};
         if (k == EDGE_RIGHT || k == EDGE_LEFT) begin
            a_in[k] = bx_in;
            n_in[k] = cx_in[k];
         end else begin
            a_in[k] = by_in;
            n_in[k] = cy_in[k];
         end
      end
   end

   // ---------------------------------------------------------------- stage 2
   logic                 s2_valid_ff;
   logic signed [DW-1:0] s2_den_ff [NUM_EDGES];
   logic signed [TW-1:0] s2_tn_ff  [NUM_EDGES];
   logic signed [UW-1:0] s2_p1_ff  [NUM_EDGES];
   logic signed [UW-1:0] s2_p2_ff  [NUM_EDGES];
   logic signed [DW-1:0] den_in    [NUM_EDGES];
   logic signed [TW-1:0] tn_in     [NUM_EDGES];
   logic signed [UW-1:0] p1_in     [NUM_EDGES];
   logic signed [UW-1:0] p2_in     [NUM_EDGES];

   // Cross-product terms, one multiplier each
   always_comb begin
      for (int k = 0; k < NUM_EDGES; k++) begin
         den_in[k] = s1_a_ff[k] * s1_f_ff[k];
         tn_in[k]  = s1_n_ff[k] * s1_f_ff[k];
         p1_in[k]  = s1_cx_ff[k] * s1_by_ff;
         p2_in[k]  = s1_cy_ff[k] * s1_bx_ff;
      end
   end

   // ---------------------------------------------------------------- stage 3
   logic                 s3_valid_ff;
   logic signed [PW-1:0] s3_den_ff [NUM_EDGES];
   logic signed [PW-1:0] s3_tn_ff  [NUM_EDGES];
   logic signed [PW-1:0] s3_un_ff  [NUM_EDGES];
   logic                 s3_dz_ff  [NUM_EDGES];
   logic signed [PW-1:0] den3_in   [NUM_EDGES];
   logic signed [PW-1:0] tn3_in    [NUM_EDGES];
   logic signed [PW-1:0] un3_in    [NUM_EDGES];
   logic                 dz3_in    [NUM_EDGES];

   // Widen to the compare word, form u numerator, flag parallel edges
   always_comb begin
      for (int k = 0; k < NUM_EDGES; k++) begin
         den3_in[k] = {{(PW-DW){s2_den_ff[k][DW-1]}}, s2_den_ff[k]};
         tn3_in[k]  = {{(PW-TW){s2_tn_ff[k][TW-1]}}, s2_tn_ff[k]};
         un3_in[k]  = {s2_p1_ff[k][UW-1], s2_p1_ff[k]} - {s2_p2_ff[k][UW-1], s2_p2_ff[k]};
         dz3_in[k]  = (s2_den_ff[k] == '0);
      end
   end

   // ---------------------------------------------------------------- stage 4
   logic          rsp_valid_ff;
   logic          rsp_hit_ff;
   edge_mask_type rsp_mask_ff;
   edge_mask_type mask_in;

   // Range compares on both parameters
   always_comb begin
      for (int k = 0; k < NUM_EDGES; k++) begin
         mask_in[k] = !s3_dz_ff[k] && in_unit(s3_tn_ff[k], s3_den_ff[k])
                      && in_unit(s3_un_ff[k], s3_den_ff[k]);
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      s1_bx_ff <= bx_in;
      s1_by_ff <= by_in;
      for (int k = 0; k < NUM_EDGES; k++) begin
         s1_a_ff[k]   <= a_in[k];
         s1_f_ff[k]   <= f_in[k];
         s1_n_ff[k]   <= n_in[k];
         s1_cx_ff[k]  <= cx_in[k];
         s1_cy_ff[k]  <= cy_in[k];
         s2_den_ff[k] <= den_in[k];
         s2_tn_ff[k]  <= tn_in[k];
         s2_p1_ff[k]  <= p1_in[k];
         s2_p2_ff[k]  <= p2_in[k];
         s3_den_ff[k] <= den3_in[k];
         s3_tn_ff[k]  <= tn3_in[k];
         s3_un_ff[k]  <= un3_in[k];
         s3_dz_ff[k]  <= dz3_in[k];
      end
      rsp_mask_ff <= mask_in;
      rsp_hit_ff  <= |mask_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_edge_mask = rsp_mask_ff;

endmodule

// ===== rtl/sri_checker.sv =====
// ----------------------------------------------------------------------------
// sri_checker
// Port-level checks of the intersection unit, bound to segment_rect_intersect_unit.
// ----------------------------------------------------------------------------
`include "segment_rect_intersect_unit_assert.svh"

module sri_checker #(
   parameter int COORD_BITS = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic signed [COORD_BITS-1:0]  req_seg_x0,
   input logic signed [COORD_BITS-1:0]  req_seg_y0,
   input logic signed [COORD_BITS-1:0]  req_seg_x1,
   input logic signed [COORD_BITS-1:0]  req_seg_y1,
   input logic        [COORD_BITS-2:0]  req_box_width,
   input logic                          rsp_valid,
   input logic                          rsp_hit,
   input sri_pkg::edge_mask_type        rsp_edge_mask
);
   import sri_pkg::*;

   logic item_taken;
   logic seg_is_point;
   logic flat_box;
   logic top_bottom_clear;

   // Accepted item and the properties of it that the checks look at
   assign item_taken       = start && !busy;
   assign seg_is_point     = (req_seg_x0 == req_seg_x1) && (req_seg_y0 == req_seg_y1);
   assign flat_box         = (req_box_width == '0);
   assign top_bottom_clear = !rsp_edge_mask[EDGE_TOP] && !rsp_edge_mask[EDGE_BOTTOM];

   // Hit flag summarizes the edge mask
   `SRI_ASSERT_IMP(a_hit_is_any_edge, rsp_valid, rsp_hit == (|rsp_edge_mask))

   // Every accepted item gives its result after the pipeline latency
   `SRI_ASSERT_DLY(a_item_latency, item_taken, PIPE_LATENCY, rsp_valid)

   // No result without an item accepted the pipeline latency earlier
   `SRI_ASSERT_IMP(a_no_spurious, rsp_valid, $past(item_taken, PIPE_LATENCY))

   // A point segment crosses nothing
   `SRI_ASSERT_DLY(a_point_misses, item_taken && seg_is_point, PIPE_LATENCY, !rsp_hit)

   // Zero width makes the top and bottom edges degenerate
   `SRI_ASSERT_DLY(a_flat_box, item_taken && flat_box, PIPE_LATENCY, top_bottom_clear)

endmodule

bind segment_rect_intersect_unit sri_checker #(.COORD_BITS(COORD_BITS)) u_sri_checker (.*);
